// File: hw/rtl/fmss_pkg.sv
// ----------------------------------------------------------------------------
// fmss_pkg: shared types and constants for the FIFO with max scan and split
// Command and result word layouts, operation and status codes, queue sizes.
// ----------------------------------------------------------------------------
package fmss_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int SIDE_DEPTH  = 16;

  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = $clog2(SIDE_DEPTH);
  localparam int SCW = $clog2(SIDE_DEPTH + 1);

  localparam logic [2:0] OP_ENQ   = 3'd0;
  localparam logic [2:0] OP_DEQ   = 3'd1;
  localparam logic [2:0] OP_MAX   = 3'd2;
  localparam logic [2:0] OP_CLR   = 3'd3;
  localparam logic [2:0] OP_SPLIT = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_SIDE_OVF = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic signed [31:0] value_in;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] value_out;
    logic [4:0]         position;
    logic [4:0]         occupancy;
  } rsp_t;

  // Circular pointer advance; the depth need not be a power of two.
  function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
    return (p == QW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Result fields carry a count masked to five bits.
  function automatic logic [4:0] to_field5(input logic [CW-1:0] c);
    logic [31:0] w;
    w = 32'(c);
    return w[4:0];
  endfunction

endpackage

// File: hw/rtl/fifo_with_max_scan_and_split.sv
// ----------------------------------------------------------------------------
// fifo_with_max_scan_and_split: bounded word FIFO with max scan and split
// Main queue is a circular buffer in a synchronous RAM; split appends the
// queued words alternately to two side buffers.
// ----------------------------------------------------------------------------
//
//  channel   signals               handshake
//  --------  --------------------  -----------------------------------------
//  command   start, busy, cmd      word taken at clock edge with start && !busy
//  result    done, rsp             word valid for one cycle while done is high
//
// Enqueue, clear, unused opcodes, and dequeue/max/split on an empty queue give
// their result in the cycle after the command; dequeue goes through S_DEQ for the
// registered RAM read. Find max and split read one stored word per cycle in S_SCAN.
// Reset is synchronous and empties all queues; the stores are not cleared. The
// result cannot be stalled, and the next command may be given in the cycle its
// predecessor's result is shown.
module fifo_with_max_scan_and_split (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  fmss_pkg::cmd_t cmd,
  output logic           done,
  output fmss_pkg::rsp_t rsp
);

  typedef enum logic [1:0] {S_IDLE, S_DEQ, S_SCAN} state_t;

  state_t                      state;
  logic [fmss_pkg::QW-1:0]     head;
  logic [fmss_pkg::QW-1:0]     tail;
  logic [fmss_pkg::CW-1:0]     count;
  logic [fmss_pkg::SCW-1:0]    odd_count;
  logic [fmss_pkg::SCW-1:0]    even_count;
  logic [fmss_pkg::QW-1:0]     rd_ptr;
  logic [fmss_pkg::CW-1:0]     idx;
  logic [2:0]                  op;
  logic signed [31:0]          best;
  logic [fmss_pkg::CW-1:0]     best_pos;
  logic                        ovf;

  logic signed [31:0]          main_mem [fmss_pkg::QUEUE_DEPTH];
  logic signed [31:0]          odd_mem  [fmss_pkg::SIDE_DEPTH];
  logic signed [31:0]          even_mem [fmss_pkg::SIDE_DEPTH];
  logic signed [31:0]          rd_data;
  logic [fmss_pkg::QW-1:0]     rd_addr;

  logic accept;
  logic enq_we;
  logic odd_we;
  logic even_we;
  logic scan_last;
  logic odd_full;
  logic even_full;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign rd_addr   = (state == S_SCAN) ? rd_ptr : head;
  assign scan_last = (idx == count - 1'b1);
  assign odd_full  = (odd_count == fmss_pkg::SCW'(fmss_pkg::SIDE_DEPTH));
  assign even_full = (even_count == fmss_pkg::SCW'(fmss_pkg::SIDE_DEPTH));

  assign enq_we  = accept && (cmd.opcode == fmss_pkg::OP_ENQ) &&
                   (count != fmss_pkg::CW'(fmss_pkg::QUEUE_DEPTH));
  // Even indexes from zero are the odd 1-based positions.
  assign odd_we  = (state == S_SCAN) && (op == fmss_pkg::OP_SPLIT) && !idx[0] && !odd_full;
  assign even_we = (state == S_SCAN) && (op == fmss_pkg::OP_SPLIT) && idx[0] && !even_full;

  always_ff @(posedge clk) begin
    if (enq_we) begin
      main_mem[tail] <= cmd.value_in;
    end
    rd_data <= main_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (odd_we) begin
      odd_mem[odd_count[fmss_pkg::SW-1:0]] <= rd_data;
    end
    if (even_we) begin
      even_mem[even_count[fmss_pkg::SW-1:0]] <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      count      <= '0;
      odd_count  <= '0;
      even_count <= '0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            op            <= cmd.opcode;
            rsp.status    <= fmss_pkg::ST_OK;
            rsp.value_out <= '0;
            rsp.position  <= '0;
            rsp.occupancy <= fmss_pkg::to_field5(count);
            best          <= '0;
            best_pos      <= '0;
            ovf           <= 1'b0;
            idx           <= '0;
            rd_ptr        <= fmss_pkg::ptr_inc(head);
            case (cmd.opcode)
              fmss_pkg::OP_ENQ: begin
                done <= 1'b1;
                if (enq_we) begin
                  tail          <= fmss_pkg::ptr_inc(tail);
                  count         <= count + 1'b1;
                  rsp.occupancy <= fmss_pkg::to_field5(count + 1'b1);
                end else begin
                  rsp.status <= fmss_pkg::ST_FULL;
                end
              end
              fmss_pkg::OP_DEQ: begin
                if (count == '0) begin
                  rsp.status <= fmss_pkg::ST_EMPTY;
                  done       <= 1'b1;
                end else begin
                  state <= S_DEQ;
                end
              end
              fmss_pkg::OP_MAX, fmss_pkg::OP_SPLIT: begin
                if (count == '0) begin
                  done <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              fmss_pkg::OP_CLR: begin
                head          <= '0;
                tail          <= '0;
                count         <= '0;
                rsp.occupancy <= '0;
                done          <= 1'b1;
              end
              default: begin
                done <= 1'b1;
              end
            endcase
          end
        end
        S_DEQ: begin
          rsp.value_out <= rd_data;
          rsp.occupancy <= fmss_pkg::to_field5(count - 1'b1);
          head          <= fmss_pkg::ptr_inc(head);
          count         <= count - 1'b1;
          done          <= 1'b1;
          state         <= S_IDLE;
        end
        S_SCAN: begin
          rd_ptr <= fmss_pkg::ptr_inc(rd_ptr);
          idx    <= idx + 1'b1;
          if (op == fmss_pkg::OP_SPLIT) begin
            if (odd_we) begin
              odd_count <= odd_count + 1'b1;
            end
            if (even_we) begin
              even_count <= even_count + 1'b1;
            end
            if (scan_last) begin
              head          <= '0;
              tail          <= '0;
              count         <= '0;
              rsp.occupancy <= '0;
              rsp.status    <= (ovf || (idx[0] ? even_full : odd_full))
                               ? fmss_pkg::ST_SIDE_OVF : fmss_pkg::ST_OK;
              done          <= 1'b1;
              state         <= S_IDLE;
            end else if (idx[0] ? even_full : odd_full) begin
              ovf <= 1'b1;
            end
          end else begin
            // Strict compare keeps the earliest of equal maxima.
            if (rd_data > best) begin
              best     <= rd_data;
              best_pos <= idx + 1'b1;
            end
            if (scan_last) begin
              rsp.value_out <= (rd_data > best) ? rd_data : best;
              rsp.position  <= fmss_pkg::to_field5((rd_data > best) ? idx + 1'b1 : best_pos);
              done          <= 1'b1;
              state         <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= fmss_pkg::CW'(fmss_pkg::QUEUE_DEPTH))
    else $error("queue count above depth");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result shown while still busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("accepted command neither busy nor done");

  a_scan_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (idx < count))
    else $error("scan index past queue count");
`endif

endmodule

// File: bench/fifo_with_max_scan_and_split_tb.sv
// ----------------------------------------------------------------------------
// fifo_with_max_scan_and_split_tb: self-checking bench for the scan/split FIFO
// A directed table covers empty, full, sign extremes, tied maxima, unused
// opcodes and split, then biased random commands with random gaps follow.
// Every result word is checked against the table's word or an in-bench model.
// ----------------------------------------------------------------------------
module fifo_with_max_scan_and_split_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fmss_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int         RANDOM_CMDS = 1400;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] val;
    int          reps;
    bit          typed;
    rsp_t        want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  cmd_t cmd = '0;
  logic done;
  rsp_t rsp;

  fifo_with_max_scan_and_split dut (
    .clk  (clk),
    .rst  (rst),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .done (done),
    .rsp  (rsp)
  );

  always #10 clk = ~clk;

  // Model of the queues.
  logic [31:0] main_mem [QUEUE_DEPTH];
  int unsigned q_head = 0;
  int unsigned q_count = 0;
  int unsigned odd_fill = 0;
  int unsigned even_fill = 0;

  rsp_t pending_rsp [$];
  row_t script [$];
  int   mismatches = 0;

  function automatic rsp_t predict_response(cmd_t c);
    rsp_t r;
    logic signed [31:0] best;
    logic [31:0] w;
    r = '0;
    r.status = ST_OK;
    case (c.opcode)
      OP_ENQ: begin
        if (q_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          main_mem[(q_head + q_count) % QUEUE_DEPTH] = c.value_in;
          q_count++;
        end
      end
      OP_DEQ: begin
        if (q_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.value_out = main_mem[q_head];
          q_head = (q_head + 1) % QUEUE_DEPTH;
          q_count--;
        end
      end
      OP_MAX: begin
        // The running maximum starts at zero, so only positive words count.
        best = '0;
        for (int i = 0; i < q_count; i++) begin
          w = main_mem[(q_head + i) % QUEUE_DEPTH];
          if ($signed(w) > best) begin
            best = w;
            r.value_out = w;
            r.position = 5'(i + 1);
          end
        end
      end
      OP_CLR: begin
        q_head = 0;
        q_count = 0;
      end
      OP_SPLIT: begin
        // Side queues never drain, so only their fill levels matter here.
        for (int i = 0; i < q_count; i++) begin
          if (i % 2 == 0) begin
            if (odd_fill >= SIDE_DEPTH) r.status = ST_SIDE_OVF;
            else odd_fill++;
          end else begin
            if (even_fill >= SIDE_DEPTH) r.status = ST_SIDE_OVF;
            else even_fill++;
          end
        end
        q_head = 0;
        q_count = 0;
      end
      default: begin
      end
    endcase
    r.occupancy = 5'(q_count);
    return r;
  endfunction

  function automatic void add_row(logic [2:0] op, logic [31:0] val, int reps = 1,
                                  bit typed = 0, logic [1:0] st = ST_OK,
                                  logic [31:0] vo = '0, logic [4:0] pos = '0,
                                  logic [4:0] occ = '0);
    row_t r;
    r.op = op;
    r.val = val;
    r.reps = reps;
    r.typed = typed;
    r.want.status = st;
    r.want.value_out = vo;
    r.want.position = pos;
    r.want.occupancy = occ;
    script.push_back(r);
  endfunction

  function automatic int pick_gap(bit quiet);
    int k;
    k = $urandom_range(0, 99);
    if (quiet || k < 55) return 0;
    if (k < 85) return $urandom_range(1, 3);
    if (k < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4, 5: return 32'($signed($urandom_range(0, 40)) - 20);
      default: return $urandom;
    endcase
  endfunction

  // Hold the word on the command port until it is taken, then record what
  // the block must answer. Start stays high for a back-to-back word.
  task automatic issue(cmd_t c, bit typed, rsp_t want);
    rsp_t got;
    start <= 1'b1;
    cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    got = predict_response(c);
    pending_rsp.push_back(typed ? want : got);
  endtask

  task automatic idle_for(int g);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && done === 1'b1) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: status %0d value %h pos %0d occ %0d",
                   rsp.status, rsp.value_out, rsp.position, rsp.occupancy);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status !== want.status || rsp.value_out !== want.value_out ||
            rsp.position !== want.position || rsp.occupancy !== want.occupancy) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result mismatch (expected/actual): status %0d/%0d value %h/%h pos %0d/%0d occ %0d/%0d",
                     want.status, rsp.status, want.value_out, rsp.value_out,
                     want.position, rsp.position, want.occupancy, rsp.occupancy);
        end
      end
    end
  end

  initial begin : stimulus
    cmd_t c;
    rsp_t none;
    int   enq_pct;
    int   k;
    int   waited;
    bit   quiet;
    none = '0;
    enq_pct = 65;
    quiet = 0;

    add_row(OP_DEQ,   32'h0,         1, 1, ST_EMPTY, 32'h0, 5'd0, 5'd0);
    add_row(OP_MAX,   32'hFFFF_FFFF, 1, 1, ST_OK,    32'h0, 5'd0, 5'd0);
    add_row(OP_SPLIT, 32'h0,         1, 1, ST_OK,    32'h0, 5'd0, 5'd0);
    add_row(OP_ENQ,   32'h8000_0000, 1, 1, ST_OK,    32'h0, 5'd0, 5'd1);
    add_row(OP_ENQ,   32'hFFFF_FFFF, 1, 1, ST_OK,    32'h0, 5'd0, 5'd2);
    add_row(OP_MAX,   32'h0,         1, 1, ST_OK,    32'h0, 5'd0, 5'd2);
    add_row(OP_ENQ,   32'h7FFF_FFFF, 1, 1, ST_OK,    32'h0, 5'd0, 5'd3);
    add_row(OP_ENQ,   32'h7FFF_FFFF, 1, 1, ST_OK,    32'h0, 5'd0, 5'd4);
    add_row(OP_MAX,   32'h0,         1, 1, ST_OK,    32'h7FFF_FFFF, 5'd3, 5'd4);
    add_row(OP_DEQ,   32'h0,         1, 1, ST_OK,    32'h8000_0000, 5'd0, 5'd3);
    add_row(OP_SPARE_LO, 32'h5555_5555, 1, 1, ST_OK, 32'h0, 5'd0, 5'd3);
    add_row(OP_SPARE_HI, 32'hAAAA_AAAA, 1, 1, ST_OK, 32'h0, 5'd0, 5'd3);
    add_row(OP_SPLIT, 32'h0);
    add_row(OP_ENQ,   32'h1,         1, 1, ST_OK,    32'h0, 5'd0, 5'd1);
    add_row(OP_CLR,   32'h0,         1, 1, ST_OK,    32'h0, 5'd0, 5'd0);
    add_row(OP_ENQ,   32'h5,         15);
    add_row(OP_ENQ,   32'h7FFF_FFFF, 1, 1, ST_OK,    32'h0, 5'd0, 5'd16);
    add_row(OP_ENQ,   32'h9,         1, 1, ST_FULL,  32'h0, 5'd0, 5'd16);
    add_row(OP_MAX,   32'h0,         1, 1, ST_OK,    32'h7FFF_FFFF, 5'd16, 5'd16);
    add_row(OP_DEQ,   32'h0);
    add_row(OP_ENQ,   32'h0);
    add_row(OP_SPLIT, 32'h0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (script[r]) begin
      for (int n = 0; n < script[r].reps; n++) begin
        idle_for(pick_gap(0));
        c.opcode = script[r].op;
        c.value_in = script[r].val;
        issue(c, script[r].typed, script[r].want);
      end
    end

    for (int n = 0; n < RANDOM_CMDS; n++) begin
      // Swing between filling and draining so both ends of the queue are hit.
      if (n % 60 == 0) enq_pct = ($urandom_range(0, 1) == 1) ? 65 : 30;
      if (n % 100 == 0) quiet = ($urandom_range(0, 3) == 0);
      k = $urandom_range(0, 99);
      if (k < enq_pct)  c.opcode = OP_ENQ;
      else if (k < 75)  c.opcode = OP_DEQ;
      else if (k < 88)  c.opcode = OP_MAX;
      else if (k < 92)  c.opcode = OP_CLR;
      else if (k < 97)  c.opcode = OP_SPLIT;
      else              c.opcode = OP_SPARE_LO + 3'($urandom_range(0, 2));
      c.value_in = pick_word();
      idle_for(pick_gap(quiet));
      issue(c, 0, none);
    end
    start <= 1'b0;

    waited = 0;
    while (pending_rsp.size() != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    repeat (40) @(posedge clk);
    if (pending_rsp.size() != 0) begin
      mismatches++;
      $display("%0d result words never arrived", pending_rsp.size());
    end

    if (mismatches == 0) begin
      $display("fifo_with_max_scan_and_split_tb: done, clean");
    end else begin
      $display("fifo_with_max_scan_and_split_tb: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("fifo_with_max_scan_and_split_tb: done, errors");
    $finish;
  end

endmodule
